/* hdl/pptl_pkg.sv */
// Package for the partition table locator: result codes, table layout
// constants and the extended-type test used by the engine.
// No dependencies.
package pptl_pkg;

	localparam int unsigned SECTOR_BYTES = 512;
	localparam int unsigned POS_W        = 9;

	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(SECTOR_BYTES - 1);
	localparam logic [POS_W-1:0] POS_MARK   = POS_W'(SECTOR_BYTES - 2);
	localparam logic [POS_W-1:0] TABLE_OFS  = 9'h1be;
	localparam logic [POS_W-1:0] TABLE_END  = 9'h1fe;

	localparam logic [7:0] MARK_LO  = 8'h55;
	localparam logic [7:0] MARK_HI  = 8'hAA;
	localparam logic [7:0] EXT_DOS  = 8'h05;
	localparam logic [7:0] EXT_LBA  = 8'h0f;
	localparam logic [7:0] EXT_LNX  = 8'h85;
	localparam logic [7:0] FIRST_LOGICAL = 8'd4;

	// Entry field offsets
	localparam logic [3:0] FLD_TYPE      = 4'd4;
	localparam logic [3:0] FLD_START_TOP = 4'd11;

	typedef enum logic [2:0] {
		ST_READ_NEXT       = 3'd0,
		ST_FOUND           = 3'd1,
		ST_PRIMARY_MISSING = 3'd2,
		ST_NO_EXTENDED     = 3'd3,
		ST_LOGICAL_EMPTY   = 3'd4,
		ST_LOGICAL_MISSING = 3'd5,
		ST_NO_MARK         = 3'd6,
		ST_READ_ERROR      = 3'd7
	} status_t;

	typedef struct packed {
		logic [31:0] sector_count;
		logic [31:0] start_sector;
		logic [31:0] next_sector;
		status_t     status;
	} result_t;

	function automatic logic is_ext_type(input logic [7:0] t);
		return (t == EXT_DOS) || (t == EXT_LBA) || (t == EXT_LNX);
	endfunction

endpackage

/* hdl/pc_partition_table_locator_top.sv */
// Flow: a byte transfer lands in the input register, and its result, if any,
// is loaded from there into the output register when that byte advances.
// Throughput: one byte per cycle, set by the capture/decide stage; input
// stalls only while a result byte waits on a full, stalled output.
// Reset: arst_n clears the search state, the target register and all valids.
// Top level of the partition table locator. Depends on pptl_pkg, pptl_engine.
module pc_partition_table_locator_top
	import pptl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: target_partition[7:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte[7:0], byte_pos[16:8], zero pad[23:17]
	input  logic [23:0] s_tdata,
	// read_error[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_sector[31:0], part_start[63:32], part_length[95:64]
	output logic [95:0] m_tdata,
	// status[2:0]
	output logic [2:0]  m_tuser
);

	logic [7:0]       target_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [POS_W-1:0] pos_s1;
	logic             err_s1;
	logic             out_valid_q;
	result_t          out_res_q;
	logic             has_result;
	result_t          result;
	logic             advance;

	assign cfg_ready = 1'b1;

	// Hold the target register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			target_q <= cfg_data;
		end
	end

	// Advance unless a result has nowhere to go
	assign advance  = valid_s1 && (!has_result || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			pos_s1  <= s_tdata[16:8];
			err_s1  <= s_tuser[0];
		end
	end

	pptl_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.data_byte        (byte_s1),
		.byte_pos         (pos_s1),
		.read_error       (err_s1),
		.target_partition (target_q),
		.has_result       (has_result),
		.result           (result)
	);

	// Load the result register; drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.sector_count, out_res_q.start_sector, out_res_q.next_sector};
	assign m_tuser  = out_res_q.status;

endmodule

/* hdl/pptl_engine.sv */
// Search engine: captures table entries byte by byte and decides at the
// last byte of each sector or on a read error. Depends on pptl_pkg.
module pptl_engine
	import pptl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic [POS_W-1:0] byte_pos,
	input  logic             read_error,
	input  logic [7:0]       target_partition,
	output logic             has_result,
	output result_t          result
);

	logic        in_logical_q, in_logical_d;
	logic [31:0] cur_table_q, cur_table_d;
	logic [31:0] ext_base_q, ext_base_d;
	logic [7:0]  log_cnt_q, log_cnt_d;
	logic        ext_seen_q, ext_seen_d;
	logic [7:0]  chosen_type_q, chosen_type_d;
	logic [3:0][7:0] chosen_start_q, chosen_start_d;
	logic [3:0][7:0] chosen_len_q, chosen_len_d;
	logic [7:0]  link_type_q, link_type_d;
	logic [3:0][7:0] link_start_q, link_start_d;
	logic        mark_lo_q, mark_lo_d;

	logic [POS_W-1:0] ofs;
	logic [1:0]       entry;
	logic [3:0]       field;
	logic             in_table;
	logic [7:0]       want;
	logic             mark_ok;

	assign ofs      = byte_pos - TABLE_OFS;
	assign entry    = ofs[5:4];
	assign field    = ofs[3:0];
	assign in_table = (byte_pos >= TABLE_OFS) && (byte_pos < TABLE_END);
	assign want     = in_logical_q ? 8'd0 : target_partition;
	assign mark_ok  = mark_lo_q && (data_byte == MARK_HI);
	assign has_result = read_error || (byte_pos == POS_LAST);

	// Capture entry fields, then decide on the last byte or a read error
	always_comb begin
		in_logical_d   = in_logical_q;
		cur_table_d    = cur_table_q;
		ext_base_d     = ext_base_q;
		log_cnt_d      = log_cnt_q;
		ext_seen_d     = ext_seen_q;
		chosen_type_d  = chosen_type_q;
		chosen_start_d = chosen_start_q;
		chosen_len_d   = chosen_len_q;
		link_type_d    = link_type_q;
		link_start_d   = link_start_q;
		mark_lo_d      = mark_lo_q;
		result         = '0;
		result.status  = ST_READ_NEXT;

		if (read_error) begin
			result.status = ST_READ_ERROR;
		end else begin
			if (byte_pos == '0) begin
				ext_seen_d = 1'b0;
			end
			if (byte_pos == POS_MARK) begin
				mark_lo_d = (data_byte == MARK_LO);
			end
			if (in_table) begin
				if ({6'd0, entry} == want) begin
					if (field == FLD_TYPE) begin
						chosen_type_d = data_byte;
					end else if (field[3:2] == 2'b10) begin
						chosen_start_d[field[1:0]] = data_byte;
					end else if (field[3:2] == 2'b11) begin
						chosen_len_d[field[1:0]] = data_byte;
					end
				end
				if (in_logical_q) begin
					if (entry == 2'd1) begin
						if (field == FLD_TYPE) begin
							link_type_d = data_byte;
						end else if (field[3:2] == 2'b10) begin
							link_start_d[field[1:0]] = data_byte;
						end
					end
				end else if (!ext_seen_q) begin
					// Track the first extended entry of the primary table
					if (field == FLD_TYPE) begin
						link_type_d = data_byte;
					end else if (field[3:2] == 2'b10) begin
						link_start_d[field[1:0]] = data_byte;
						if (field == FLD_START_TOP && is_ext_type(link_type_q)) begin
							ext_seen_d = 1'b1;
						end
					end
				end
			end

			if (byte_pos == POS_LAST) begin
				if (!in_logical_q) begin
					if (!mark_ok) begin
						result.status = ST_NO_MARK;
					end else if (target_partition < FIRST_LOGICAL) begin
						if (chosen_type_q == '0 || is_ext_type(chosen_type_q)) begin
							result.status = ST_PRIMARY_MISSING;
						end else begin
							result.status       = ST_FOUND;
							result.start_sector = chosen_start_q;
							result.sector_count = chosen_len_q;
						end
					end else if (!ext_seen_q) begin
						result.status = ST_NO_EXTENDED;
					end else begin
						ext_base_d         = link_start_q;
						cur_table_d        = link_start_q;
						log_cnt_d          = FIRST_LOGICAL;
						in_logical_d       = 1'b1;
						result.next_sector = link_start_q;
					end
				end else begin
					if (!mark_ok) begin
						result.status = ST_LOGICAL_MISSING;
					end else if (log_cnt_q == target_partition) begin
						if (chosen_type_q == '0) begin
							result.status = ST_LOGICAL_EMPTY;
						end else begin
							result.status       = ST_FOUND;
							result.start_sector = cur_table_q + chosen_start_q;
							result.sector_count = chosen_len_q;
						end
					end else if (!is_ext_type(link_type_q)) begin
						result.status = ST_LOGICAL_MISSING;
					end else begin
						cur_table_d        = ext_base_q + link_start_q;
						log_cnt_d          = log_cnt_q + 8'd1;
						result.next_sector = ext_base_q + link_start_q;
					end
				end
			end
		end

		// Start over at sector 0 after an error or a final answer
		if (has_result && result.status != ST_READ_NEXT) begin
			in_logical_d = 1'b0;
			cur_table_d  = '0;
			ext_base_d   = '0;
			log_cnt_d    = FIRST_LOGICAL;
		end
	end

	// Advance search state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_logical_q   <= 1'b0;
			cur_table_q    <= '0;
			ext_base_q     <= '0;
			log_cnt_q      <= FIRST_LOGICAL;
			ext_seen_q     <= 1'b0;
			chosen_type_q  <= '0;
			chosen_start_q <= '0;
			chosen_len_q   <= '0;
			link_type_q    <= '0;
			link_start_q   <= '0;
			mark_lo_q      <= 1'b0;
		end else if (step) begin
			in_logical_q   <= in_logical_d;
			cur_table_q    <= cur_table_d;
			ext_base_q     <= ext_base_d;
			log_cnt_q      <= log_cnt_d;
			ext_seen_q     <= ext_seen_d;
			chosen_type_q  <= chosen_type_d;
			chosen_start_q <= chosen_start_d;
			chosen_len_q   <= chosen_len_d;
			link_type_q    <= link_type_d;
			link_start_q   <= link_start_d;
			mark_lo_q      <= mark_lo_d;
		end
	end

endmodule

/* hdl/pptl_checker.sv */
// Port-level checker for the partition table locator, bound to the top.
// Depends on pptl_pkg.
module pptl_checker
	import pptl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Next sector is only given with a read-next status
	a_next_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_READ_NEXT |-> m_tdata[31:0] == 32'd0)
		else $error("next_sector set on a final status");

	// Partition bounds only given when found
	a_part_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_FOUND |-> m_tdata[95:32] == 64'd0)
		else $error("partition bounds set without found status");

	// An empty result register never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

bind pc_partition_table_locator_top pptl_checker u_pptl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
